/* rtl/core/rqra_pkg.sv */
// Package: sizes, widths and sequencer states of the ring queue running average block.
package rqra_pkg;

  // Storage slots; one slot stays unused, so the queue holds SLOTS-1 entries
  localparam int SLOTS = 8;

  localparam int YEAR_W    = 14;
  localparam int ENTRIES_W = 3;
  localparam int IDX_W     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int SUM_W     = YEAR_W + CNT_W;
  localparam int BIT_W     = $clog2(SUM_W);

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOTS - 1);

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_STORE,
    ST_DIV,
    ST_FINISH
  } rqra_state_e;

  // Advance a slot index around the ring
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_LAST) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

/* rtl/core/ring_queue_running_average.sv */
// Top level: ring queue of year values with running sum and iterative mean divider.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i, in_stall_o | req_type_i, year_value_i
//   out     | output    | out_valid_o, out_stall_i | avg_year_o, removed_year_o,
//           |           |                        | evicted_o, empty_error_o, entries_held_o
//
// An insert runs store, the divider steps and finish, with a take step first when it
// evicts; the restoring divider forms sum / count one quotient bit a cycle. A remove
// runs take and finish, an empty remove finish alone. One item is in work at a time.
// Reset (rst_ni low, asynchronous) empties the queue and zeroes the sum.
// The result register holds while out_stall_i is high; a new item may be taken
// meanwhile, and the sequencer waits in its last step until the register frees.
module ring_queue_running_average
  import rqra_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [YEAR_W-1:0] year_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [YEAR_W-1:0] avg_year_o,
  output logic [YEAR_W-1:0] removed_year_o,
  output logic              evicted_o,
  output logic              empty_error_o,
  output logic [ENTRIES_W-1:0] entries_held_o
);

  rqra_state_e state_q, state_d;

  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  logic              req_q, req_d;
  logic [YEAR_W-1:0] year_q, year_d;
  logic              evict_q, evict_d;
  logic              err_q, err_d;
  logic [YEAR_W-1:0] taken_q, taken_d;

  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [BIT_W-1:0]  bit_q, bit_d;

  logic              out_valid_q, out_valid_d;
  logic [YEAR_W-1:0] avg_q, avg_d;
  logic [YEAR_W-1:0] removed_q, removed_d;
  logic              evicted_q, evicted_d;
  logic              empty_err_q, empty_err_d;
  logic [ENTRIES_W-1:0] entries_q, entries_d;

  logic [YEAR_W-1:0] slot_mem_q [SLOTS];
  logic [YEAR_W-1:0] rd_q;
  logic              mem_we;

  logic              in_xfer;
  logic              out_free;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic [YEAR_W-1:0] year_clamped;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Saturate years above range
  assign year_clamped = (year_value_i > YEAR_MAX) ? YEAR_MAX : year_value_i;

  // Divider step: bring down the next dividend bit and trial-subtract the count
  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, count_q};

  // Slot memory: write at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[tail_q] <= year_q;
    end
    rd_q <= slot_mem_q[head_q];
  end

  // Sequencer state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    year_q      <= year_d;
    evict_q     <= evict_d;
    err_q       <= err_d;
    taken_q     <= taken_d;
    dvd_q       <= dvd_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    bit_q       <= bit_d;
    avg_q       <= avg_d;
    removed_q   <= removed_d;
    evicted_q   <= evicted_d;
    empty_err_q <= empty_err_d;
    entries_q   <= entries_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    sum_d       = sum_q;
    req_d       = req_q;
    year_d      = year_q;
    evict_d     = evict_q;
    err_d       = err_q;
    taken_d     = taken_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    avg_d       = avg_q;
    removed_d   = removed_q;
    evicted_d   = evicted_q;
    empty_err_d = empty_err_q;
    entries_d   = entries_q;
    mem_we      = 1'b0;

    // Drop the result once the consumer takes the transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          req_d   = req_type_i;
          year_d  = year_clamped;
          evict_d = 1'b0;
          err_d   = 1'b0;
          taken_d = '0;
          if (req_type_i == REQ_REMOVE) begin
            if (count_q == '0) begin
              err_d   = 1'b1;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_TAKE;
            end
          end else if (count_q == CNT_FULL) begin
            evict_d = 1'b1;
            state_d = ST_TAKE;
          end else begin
            state_d = ST_STORE;
          end
        end
      end

      ST_TAKE: begin
        // Pop the oldest entry off the head and out of the sum
        taken_d = rd_q;
        sum_d   = sum_q - SUM_W'(rd_q);
        head_d  = next_slot(head_q);
        count_d = count_q - CNT_W'(1);
        state_d = (req_q == REQ_REMOVE) ? ST_FINISH : ST_STORE;
      end

      ST_STORE: begin
        // Push the new value at the tail and load the divider
        mem_we  = 1'b1;
        tail_d  = next_slot(tail_q);
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_q + SUM_W'(year_q);
        dvd_d   = sum_d;
        quo_d   = '0;
        rem_d   = '0;
        bit_d   = BIT_W'(SUM_W - 1);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        // One quotient bit per cycle
        if (!trial[CNT_W]) begin
          rem_d = trial[CNT_W-1:0];
        end else begin
          rem_d = shifted[CNT_W-1:0];
        end
        quo_d = {quo_q[SUM_W-2:0], !trial[CNT_W]};
        dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
        if (bit_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end

      ST_FINISH: begin
        // Hold until the result register is free, then load it
        if (out_free) begin
          out_valid_d = 1'b1;
          avg_d       = (req_q == REQ_INSERT) ? YEAR_W'(quo_q) : '0;
          removed_d   = (req_q == REQ_REMOVE && !err_q) ? taken_q : '0;
          evicted_d   = evict_q;
          empty_err_d = err_q;
          entries_d   = ENTRIES_W'(count_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign avg_year_o     = avg_q;
  assign removed_year_o = removed_q;
  assign evicted_o      = evicted_q;
  assign empty_error_o  = empty_err_q;
  assign entries_held_o = entries_q;

  // Occupancy never passes the usable slot count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue occupancy above capacity");

  // An empty queue has head and tail on the same slot
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  // An empty-remove error reports nothing held, nothing taken and no eviction
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_error_o) |->
      (entries_held_o == '0 && removed_year_o == '0 && !evicted_o))
    else $error("empty remove reported with data");

  // A result is loaded only from the finish step
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result loaded outside finish step");

endmodule
